@@ design/trf_pkg.sv @@
`default_nettype none

package trf_pkg;

  localparam int unsigned ByteW = 8;

  // telnet command codes
  localparam logic [ByteW-1:0] CODE_IAC  = 8'hff;
  localparam logic [ByteW-1:0] CODE_DONT = 8'hfe;
  localparam logic [ByteW-1:0] CODE_DO   = 8'hfd;
  localparam logic [ByteW-1:0] CODE_WONT = 8'hfc;
  localparam logic [ByteW-1:0] CODE_WILL = 8'hfb;

  // register file
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_OPT_A = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OPT_B = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OPT_C = 2'd2;

  localparam logic [ByteW-1:0] OPT_A_RST = 8'd0;
  localparam logic [ByteW-1:0] OPT_B_RST = 8'd3;
  localparam logic [ByteW-1:0] OPT_C_RST = 8'd1;

  localparam int unsigned MaxBeats = 3;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_IAC  = 3'd1,
    PH_WILL = 3'd2,
    PH_WONT = 3'd3,
    PH_DO   = 3'd4,
    PH_DONT = 3'd5
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             block_end;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             to_peer;
    logic             last_of_run;
  } out_t;

  // results of one received byte, beat 0 first
  typedef struct packed {
    logic [1:0]               cnt;
    out_t [MaxBeats-1:0]      beat;
  } burst_t;

  // buffer status seen by the top level
  typedef struct packed {
    logic [1:0] pending;
    logic [1:0] rd_ptr;
  } buf_stat_t;

endpackage

`default_nettype wire

@@ design/trf_decode.sv @@
`default_nettype none

module trf_decode (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [trf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [trf_pkg::ByteW-1:0]     cfg_data_i,
  input  wire                          take_i,
  input  trf_pkg::in_t                 in_i,
  output trf_pkg::burst_t              burst_o
);
  import trf_pkg::*;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] opt_a_q, opt_b_q, opt_c_q;
  logic [ByteW-1:0] b;
  logic             accepted;

  assign b        = in_i.rx_byte;
  assign accepted = (b == opt_a_q) || (b == opt_b_q) || (b == opt_c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opt_a_q <= OPT_A_RST;
      opt_b_q <= OPT_B_RST;
      opt_c_q <= OPT_C_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OPT_A: opt_a_q <= cfg_data_i;
        CFG_OPT_B: opt_b_q <= cfg_data_i;
        CFG_OPT_C: opt_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else if (take_i) begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    phase_d      = PH_IDLE;
    burst_o      = '0;
    unique case (phase_q)
      PH_IAC: begin
        if (b == CODE_WILL) begin
          phase_d = PH_WILL;
        end else if (b == CODE_WONT) begin
          phase_d = PH_WONT;
        end else if (b == CODE_DO) begin
          phase_d = PH_DO;
        end else if (b == CODE_DONT) begin
          phase_d = PH_DONT;
        end else if (b == CODE_IAC) begin
          burst_o.cnt     = 2'd1;
          burst_o.beat[0] = '{out_byte: CODE_IAC, to_peer: 1'b0, last_of_run: 1'b1};
        end else begin
          burst_o.cnt     = 2'd2;
          burst_o.beat[0] = '{out_byte: CODE_IAC, to_peer: 1'b0, last_of_run: 1'b0};
          burst_o.beat[1] = '{out_byte: b, to_peer: 1'b0, last_of_run: 1'b1};
        end
      end
      PH_WILL, PH_DO: begin
        if (!accepted) begin
          burst_o.cnt     = 2'd3;
          burst_o.beat[0] = '{out_byte: CODE_IAC, to_peer: 1'b1, last_of_run: 1'b0};
          burst_o.beat[1] = '{out_byte: (phase_q == PH_WILL) ? CODE_DONT : CODE_WONT,
                              to_peer: 1'b1, last_of_run: 1'b0};
          burst_o.beat[2] = '{out_byte: b, to_peer: 1'b1, last_of_run: 1'b1};
        end
      end
      PH_WONT, PH_DONT: ;
      default: begin
        // idle, and any stray phase code
        if (b == CODE_IAC) begin
          phase_d = PH_IAC;
        end else begin
          burst_o.cnt     = 2'd1;
          burst_o.beat[0] = '{out_byte: b, to_peer: 1'b0, last_of_run: 1'b1};
        end
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/trf_burst.sv @@
`default_nettype none

module trf_burst (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 load_i,
  input  trf_pkg::burst_t     burst_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output trf_pkg::out_t       out_o,
  output trf_pkg::buf_stat_t  stat_o
);
  import trf_pkg::*;

  out_t       beat_q [MaxBeats];
  logic [1:0] pending_q, pending_d;
  logic [1:0] rd_q, rd_d;
  logic       pop;

  assign out_valid_o = (pending_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign can_load_o  = (pending_q == 2'd0) || ((pending_q == 2'd1) && out_ready_i);
  assign out_o       = beat_q[rd_q];
  assign stat_o      = '{pending: pending_q, rd_ptr: rd_q};

  always_comb begin
    pending_d = pending_q;
    rd_d      = rd_q;
    if (load_i) begin
      pending_d = burst_i.cnt;
      rd_d      = 2'd0;
    end else if (pop) begin
      pending_d = pending_q - 2'd1;
      rd_d      = rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
      rd_q      <= 2'd0;
    end else begin
      pending_q <= pending_d;
      rd_q      <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < MaxBeats; i++) begin
        beat_q[i] <= burst_i.beat[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ design/telnet_receive_filter.sv @@
`default_nettype none

// telnet receive filter: strips telnet commands from a received byte stream.
// plain bytes come out as data (to_peer low); iac iac gives one 255 data byte;
// iac will/do with an option that matches none of the three accepted option
// registers gives a three-byte refusal to the peer (iac dont opt or iac wont
// opt, to_peer high); iac wont/dont opt is dropped; iac with any other byte
// passes both bytes as data. last_of_run marks the final result of one input
// byte; bytes that only advance a command give no result. block_end does not
// affect filtering, partial commands carry across blocks.
// rate: one byte per cycle when each byte yields at most one result and the
// output is ready. the result buffer drains one beat a cycle while the output
// is ready, so a byte giving several results holds the input until only its
// final beat is left. input is taken while that final beat is being accepted.
// results are registered: a result appears the cycle after its byte is taken.
// the option registers are written through cfg_we_i / cfg_idx_i / cfg_data_i
// (0: option a, reset 0; 1: option b, reset 3; 2: option c, reset 1); an
// index beyond these is ignored. write only while the block is idle.
module telnet_receive_filter (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // option registers
  input  wire                         cfg_we_i,
  input  wire [trf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [trf_pkg::ByteW-1:0]    cfg_data_i,
  // received byte request
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  trf_pkg::in_t                in_i,
  // filtered byte request
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output trf_pkg::out_t               out_o
);
  import trf_pkg::*;

  burst_t    burst;
  buf_stat_t stat;
  logic      take;

  // a new byte is taken once the buffer is empty or is handing off its last beat
  assign take = in_valid_i && in_ready_o;

  // parser: phase register, option registers and the per-byte result burst
  trf_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .take_i     (take),
    .in_i       (in_i),
    .burst_o    (burst)
  );

  // result register: holds up to three beats and hands them out in order
  trf_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .burst_i     (burst),
    .can_load_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .stat_o      (stat)
  );

  // a byte is only taken when no more than the final beat is still waiting
  a_take_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> (stat.pending <= 2'd1))
    else $error("byte taken while earlier results still pending");

  // last_of_run sits on exactly the final buffered beat
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.last_of_run == (stat.pending == 2'd1)))
    else $error("last_of_run out of step with buffered beats");

  // a burst never runs past its three beats
  a_burst_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, stat.pending} + {1'b0, stat.rd_ptr}) <= 3'd3)
    else $error("result buffer read past burst");

  // refusal beats are consecutive: a peer beat that is not last is followed by a peer beat
  a_refusal_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_o.to_peer && !out_o.last_of_run)
      |=> (out_valid_o && out_o.to_peer))
    else $error("refusal sequence broken");

endmodule

`default_nettype wire
